// File: hw/rtl/tile_background_window_pixel_fetch_core_assert.svh
// assertion macros shared by the tile fetch rtl
`ifndef TILE_BACKGROUND_WINDOW_PIXEL_FETCH_CORE_ASSERT_SVH
`define TILE_BACKGROUND_WINDOW_PIXEL_FETCH_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// checked while out of reset
`define TBWF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tbwf assertion failed");
// checked at every edge, reset included
`define TBWF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tbwf assertion failed");
`else
`define TBWF_ASSERT(lbl, clk, rst_n, prop)
`define TBWF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: hw/rtl/tbwf_pkg.sv
// types and constants of the tile background/window pixel fetcher
`default_nettype none
package tbwf_pkg;

  typedef enum logic [1:0] {
    CMD_RENDER     = 2'd0,
    CMD_TILE_INDEX = 2'd1,
    CMD_ATTRIBUTE  = 2'd2,
    CMD_TILE_DATA  = 2'd3
  } cmd_t;

  localparam int CfgIndexW = 3;
  localparam logic [CfgIndexW-1:0] CFG_LCD_CONTROL = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_SCROLL_X    = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_SCROLL_Y    = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_WINDOW_X    = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_WINDOW_Y    = 3'd4;

  // lcd control bits
  localparam int LcdcBgMapBit    = 3;
  localparam int LcdcUnsignedBit = 4;
  localparam int LcdcWinEnBit    = 5;
  localparam int LcdcWinMapBit   = 6;

  // attribute bits
  localparam int AttrBankBit  = 3;
  localparam int AttrHflipBit = 5;
  localparam int AttrVflipBit = 6;
  localparam int AttrPrioBit  = 7;

  localparam int MapSide       = 32;
  localparam int MapEntries    = MapSide * MapSide;
  localparam int MapAddrW      = 11;   // two maps of 32x32
  localparam int PatBankBytes  = 6144;
  localparam int PatBankWords  = PatBankBytes / 2;
  localparam int PatAddrW      = 13;   // two banks of 16-bit words
  localparam int PatBaseW      = 12;
  localparam logic [PatBaseW-1:0] SignedBaseWord = 12'h400;  // byte 0x800
  localparam logic [7:0] WinXMax    = 8'd166;
  localparam logic [8:0] WinXOffset = 9'd7;
  localparam logic [7:0] TileFlip   = 8'h80;

  typedef struct packed {
    logic [7:0] lcd_control;
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
    logic [7:0] window_x;
    logic [7:0] window_y;
  } cfg_regs_t;

  typedef struct packed {
    logic                win;
    logic [MapAddrW-1:0] map_addr;
    logic [2:0]          fine_col;
    logic [2:0]          fine_row;
  } loc_t;

endpackage
`default_nettype wire

// File: hw/rtl/tbwf_map_ram.sv
// tile index and attribute maps: 2048 x 16 with byte write enables
`default_nettype none
module tbwf_map_ram (
  input  wire logic                          clk,
  input  wire logic [1:0]                    we,
  input  wire logic [tbwf_pkg::MapAddrW-1:0] waddr,
  input  wire logic [7:0]                    wdata,
  input  wire logic                          rd_en,
  input  wire logic [tbwf_pkg::MapAddrW-1:0] raddr,
  output logic [15:0]                        rdata_r
);

  // low byte tile index, high byte attribute
  logic [15:0] mem [2**tbwf_pkg::MapAddrW];

  always_ff @(posedge clk) begin
    if (we[0]) begin
      mem[waddr][7:0] <= wdata;
    end
    if (we[1]) begin
      mem[waddr][15:8] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/tbwf_pattern_ram.sv
// tile pattern store: two banks of 3072 x 16, low byte is the even byte
`default_nettype none
module tbwf_pattern_ram (
  input  wire logic                          clk,
  input  wire logic [1:0]                    we,
  input  wire logic [tbwf_pkg::PatAddrW-1:0] waddr,
  input  wire logic [7:0]                    wdata,
  input  wire logic                          rd_en,
  input  wire logic [tbwf_pkg::PatAddrW-1:0] raddr,
  output logic [15:0]                        rdata_r
);

  logic [15:0] mem [2 * tbwf_pkg::PatBankWords];

  always_ff @(posedge clk) begin
    if (we[0]) begin
      mem[waddr][7:0] <= wdata;
    end
    if (we[1]) begin
      mem[waddr][15:8] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/tbwf_layer_sel.sv
// window/background choice and map entry address for one pixel
`default_nettype none
module tbwf_layer_sel (
  input  wire logic [7:0]          pixel_x,
  input  wire logic [7:0]          line,
  input  wire tbwf_pkg::cfg_regs_t cfg,
  output tbwf_pkg::loc_t           loc
);

  logic [8:0] px_ext;
  logic       win;
  logic       map_sel;
  logic [7:0] col;
  logic [7:0] row;

  always_comb begin
    px_ext = {1'b0, pixel_x} + tbwf_pkg::WinXOffset;
    win = cfg.lcd_control[tbwf_pkg::LcdcWinEnBit] &&
          (line >= cfg.window_y) &&
          (cfg.window_x <= tbwf_pkg::WinXMax) &&
          (px_ext >= {1'b0, cfg.window_x});
    if (win) begin
      map_sel = cfg.lcd_control[tbwf_pkg::LcdcWinMapBit];
      col     = 8'(px_ext - {1'b0, cfg.window_x});
      row     = line - cfg.window_y;
    end else begin
      map_sel = cfg.lcd_control[tbwf_pkg::LcdcBgMapBit];
      col     = pixel_x + cfg.scroll_x;
      row     = line + cfg.scroll_y;
    end
    loc.win      = win;
    loc.map_addr = {map_sel, row[7:3], col[7:3]};
    loc.fine_col = col[2:0];
    loc.fine_row = row[2:0];
  end

endmodule
`default_nettype wire

// File: hw/rtl/tile_background_window_pixel_fetch_core.sv
// top level of the tile background/window pixel fetcher
//
// usage:
//   input channel (in_valid/in_stall) carries one beat per command: render a
//   pixel, or write a tile index, an attribute or a tile data byte. writes
//   land in the map or pattern memory at the edge the beat is accepted and
//   give no result; writes past the map or bank are dropped.
//   a render beat at or beyond SCREEN_WIDTH gives no result either.
//   result channel (out_valid/out_stall) carries color code, palette, priority
//   and a window flag, one beat per on-screen render, in order.
//   config port (cfg_we/cfg_index/cfg_data) sets lcd control, scroll and
//   window position; write it only while no render is in flight.
// pipeline:
//   one beat per cycle while in_stall is low. a render reads the map as it is
//   accepted, reads the pattern word as it leaves stage 1, and has its pixel
//   selected into the output register as it leaves stage 2.
// reset: clears registers and pipeline valids; memory contents stay
//   undefined until written.
// stall: a stalled output holds; each stage keeps moving into free slots,
//   and input is held only once the render stage ahead cannot move on.
`default_nettype none
`include "tile_background_window_pixel_fetch_core_assert.svh"
module tile_background_window_pixel_fetch_core #(
  parameter int SCREEN_WIDTH = 160
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [tbwf_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     in_command,
  input  wire logic                           in_map_number,
  input  wire logic                           in_vram_bank,
  input  wire logic [12:0]                    in_write_address,
  input  wire logic [7:0]                     in_write_data,
  input  wire logic [7:0]                     in_pixel_x,
  input  wire logic [7:0]                     in_line,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          out_color_code,
  output logic [2:0]                          out_palette_number,
  output logic                                out_bg_priority,
  output logic                                out_from_window
);

  // config registers
  tbwf_pkg::cfg_regs_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tbwf_pkg::CFG_LCD_CONTROL: cfg_r.lcd_control <= cfg_data;
        tbwf_pkg::CFG_SCROLL_X:    cfg_r.scroll_x    <= cfg_data;
        tbwf_pkg::CFG_SCROLL_Y:    cfg_r.scroll_y    <= cfg_data;
        tbwf_pkg::CFG_WINDOW_X:    cfg_r.window_x    <= cfg_data;
        tbwf_pkg::CFG_WINDOW_Y:    cfg_r.window_y    <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline advance: each stage moves when its successor is free or moving
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic adv1, adv2, adv3;

  assign adv3     = !out_valid_r || !out_stall;
  assign adv2     = !s2_valid_r || adv3;
  assign adv1     = !s1_valid_r || adv2;
  assign in_stall = !adv1;

  // decode of the accepted beat
  tbwf_pkg::cmd_t cmd;
  logic           accept;
  logic           render_go;
  logic           addr_in_map;
  logic           addr_in_bank;
  logic [1:0]     map_we;
  logic [1:0]     pat_we;
  logic [tbwf_pkg::MapAddrW-1:0] map_waddr;
  logic [tbwf_pkg::PatAddrW-1:0] pat_waddr;

  always_comb begin
    cmd          = tbwf_pkg::cmd_t'(in_command);
    accept       = in_valid && !in_stall;
    addr_in_map  = in_write_address < 13'(tbwf_pkg::MapEntries);
    addr_in_bank = in_write_address < 13'(tbwf_pkg::PatBankBytes);
    render_go    = accept && (cmd == tbwf_pkg::CMD_RENDER) &&
                   ({1'b0, in_pixel_x} < 9'(SCREEN_WIDTH));
    // byte enables: low lane tile index, high lane attribute
    map_we[0]    = accept && addr_in_map && (cmd == tbwf_pkg::CMD_TILE_INDEX);
    map_we[1]    = accept && addr_in_map && (cmd == tbwf_pkg::CMD_ATTRIBUTE);
    map_waddr    = {in_map_number, in_write_address[9:0]};
    // pattern store packs each even/odd byte pair into one word
    pat_we[0]    = accept && addr_in_bank && (cmd == tbwf_pkg::CMD_TILE_DATA) &&
                   !in_write_address[0];
    pat_we[1]    = accept && addr_in_bank && (cmd == tbwf_pkg::CMD_TILE_DATA) &&
                   in_write_address[0];
    pat_waddr    = {1'b0, in_write_address[12:1]} +
                   (in_vram_bank ? 13'(tbwf_pkg::PatBankWords) : 13'd0);
  end

  // stage 0: pick the layer and read the map entry
  tbwf_pkg::loc_t loc;
  logic [15:0]    map_rdata;

  tbwf_layer_sel u_layer_sel (
    .pixel_x (in_pixel_x),
    .line    (in_line),
    .cfg     (cfg_r),
    .loc     (loc)
  );

  tbwf_map_ram u_map_ram (
    .clk     (clk),
    .we      (map_we),
    .waddr   (map_waddr),
    .wdata   (in_write_data),
    .rd_en   (render_go),
    .raddr   (loc.map_addr),
    .rdata_r (map_rdata)
  );

  logic       s1_win_r;
  logic [2:0] s1_fine_col_r;
  logic [2:0] s1_fine_row_r;

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_win_r      <= loc.win;
      s1_fine_col_r <= loc.fine_col;
      s1_fine_row_r <= loc.fine_row;
    end
  end

  // stage 1: tile number and attribute to pattern word address.
  // the pattern read happens on the edge the render leaves this stage; no
  // input is taken while it waits here, so every earlier write has landed
  logic [7:0]                    tile_idx;
  logic [7:0]                    attr;
  logic [tbwf_pkg::PatBaseW-1:0] base_word;
  logic [2:0]                    tile_row;
  logic [2:0]                    bit_sel;
  logic [tbwf_pkg::PatAddrW-1:0] pat_raddr;
  logic [15:0]                   pat_rdata;

  always_comb begin
    tile_idx = map_rdata[7:0];
    attr     = map_rdata[15:8];
    if (cfg_r.lcd_control[tbwf_pkg::LcdcUnsignedBit]) begin
      base_word = {1'b0, tile_idx, 3'b000};
    end else begin
      // offset-0x80 addressing from byte 0x800
      base_word = tbwf_pkg::SignedBaseWord + {1'b0, tile_idx ^ tbwf_pkg::TileFlip, 3'b000};
    end
    tile_row  = attr[tbwf_pkg::AttrVflipBit] ? ~s1_fine_row_r : s1_fine_row_r;
    bit_sel   = attr[tbwf_pkg::AttrHflipBit] ? s1_fine_col_r : ~s1_fine_col_r;
    pat_raddr = {1'b0, base_word} + {10'd0, tile_row} +
                (attr[tbwf_pkg::AttrBankBit] ? 13'(tbwf_pkg::PatBankWords) : 13'd0);
  end

  tbwf_pattern_ram u_pattern_ram (
    .clk     (clk),
    .we      (pat_we),
    .waddr   (pat_waddr),
    .wdata   (in_write_data),
    .rd_en   (adv2 && s1_valid_r),
    .raddr   (pat_raddr),
    .rdata_r (pat_rdata)
  );

  logic       s2_win_r;
  logic [2:0] s2_palette_r;
  logic       s2_prio_r;
  logic [2:0] s2_bit_r;

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_win_r     <= s1_win_r;
      s2_palette_r <= attr[2:0];
      s2_prio_r    <= attr[tbwf_pkg::AttrPrioBit];
      s2_bit_r     <= bit_sel;
    end
  end

  // stage 2: pick the pixel out of the two bit planes
  logic [1:0] color_code_r;
  logic [2:0] palette_r;
  logic       prio_r;
  logic       win_r;

  always_ff @(posedge clk) begin
    if (adv3) begin
      color_code_r <= {pat_rdata[8 + 32'(s2_bit_r)], pat_rdata[s2_bit_r]};
      palette_r    <= s2_palette_r;
      prio_r       <= s2_prio_r;
      win_r        <= s2_win_r;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid_r <= render_go;
      end
      if (adv2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (adv3) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_color_code     = color_code_r;
  assign out_palette_number = palette_r;
  assign out_bg_priority    = prio_r;
  assign out_from_window    = win_r;

  // a render waiting on its pattern read blocks input
  `TBWF_ASSERT(a_s1_hold_blocks_in, clk, rst_n, (s1_valid_r && !adv2) |-> in_stall)
  // an on-screen render enters the map read stage
  `TBWF_ASSERT(a_render_enters_s1, clk, rst_n, render_go |=> s1_valid_r)
  // a new result only comes from the pattern stage
  `TBWF_ASSERT(a_out_from_s2, clk, rst_n, $rose(out_valid_r) |-> $past(s2_valid_r))
  // reset empties the pipeline
  `TBWF_ASSERT_ALWAYS(a_reset_empty, clk,
                      !rst_n |=> (!s1_valid_r && !s2_valid_r && !out_valid_r))

endmodule
`default_nettype wire
